// ----- design/life_automaton_grid_defines.svh -----
// assertion macros for the life grid checker
// used by lag_checker.sv; expects clock and reset in scope
`ifndef LIFE_AUTOMATON_GRID_DEFINES_SVH
`define LIFE_AUTOMATON_GRID_DEFINES_SVH

// antecedent holds, consequent in the same cycle
`define LAG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds, consequent in the next cycle
`define LAG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/lag_pkg.sv -----
// shared types and constants for the life automaton grid
// no dependencies; imported by lag_next_row, life_automaton_grid and lag_checker
package lag_pkg;

   localparam logic [1:0] KIND_SET  = 2'd0;
   localparam logic [1:0] KIND_STEP = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   localparam logic [3:0] BIRTH_COUNT = 4'd3;
   localparam logic [3:0] SURVIVE_MIN = 4'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [6:0] cell_x;
      logic [5:0] cell_y;
   } lag_req_type;

   typedef struct packed {
      logic       cell_alive;
      logic [1:0] done_kind;
   } lag_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_PRIME,
      ST_SWEEP,
      ST_DONE
   } lag_state_type;

endpackage

// ----- design/lag_cell_mem.sv -----
// row-organised cell memory: one write port, one registered read port
// no package dependencies
module lag_cell_mem #(
   parameter int ROWS = 40,
   parameter int COLS = 100
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [$clog2(ROWS)-1:0] wr_addr,
   input  logic [COLS-1:0]         wr_data,
   input  logic [$clog2(ROWS)-1:0] rd_addr,
   output logic [COLS-1:0]         rd_data
);

   logic [COLS-1:0] mem [ROWS];
   logic [COLS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lag_next_row.sv -----
// next-generation logic for one whole row from three old rows
// depends on lag_pkg for the rule constants
module lag_next_row #(
   parameter int GRID_WIDTH = 100
) (
   input  logic [GRID_WIDTH-1:0] prev_row,
   input  logic [GRID_WIDTH-1:0] cur_row,
   input  logic [GRID_WIDTH-1:0] next_row,
   output logic [GRID_WIDTH-1:0] new_row
);
   import lag_pkg::*;

   // dead columns either side stand in for the border
   logic [GRID_WIDTH+1:0] prev_pad;
   logic [GRID_WIDTH+1:0] cur_pad;
   logic [GRID_WIDTH+1:0] next_pad;

   assign prev_pad = {1'b0, prev_row, 1'b0};
   assign cur_pad  = {1'b0, cur_row, 1'b0};
   assign next_pad = {1'b0, next_row, 1'b0};

   for (genvar x = 0; x < GRID_WIDTH; x++) begin : g_col
      logic [3:0] cnt;

      assign cnt = 4'(prev_pad[x]) + 4'(prev_pad[x+1]) + 4'(prev_pad[x+2])
                 + 4'(cur_pad[x])                      + 4'(cur_pad[x+2])
                 + 4'(next_pad[x]) + 4'(next_pad[x+1]) + 4'(next_pad[x+2]);

      assign new_row[x] = cur_row[x] ? (cnt == SURVIVE_MIN || cnt == BIRTH_COUNT)
                                     : (cnt == BIRTH_COUNT);
   end

endmodule

// ----- design/life_automaton_grid.sv -----
// top level of the life automaton grid: control sequencer and row datapath
// depends on lag_pkg, lag_cell_mem and lag_next_row
//
// A GRID_WIDTH by GRID_HEIGHT grid of cells running B3/S23 with dead borders.
// Every accepted request gives one response. After reset the block clears the
// cell memory one row a cycle and holds req_stall high until the last row is clear.
// Requests are handled one at a time: a set or read passes through a memory read,
// a modify or select and a response load, and a set or read outside the grid or an
// unknown kind goes straight to the response load; a step primes the row registers,
// then sweeps the row memory one row per cycle while two row registers hold the old
// row above and the old row being rewritten, and then loads the response.
// A new request is taken while a finished response still waits on rsp_stall.
module life_automaton_grid #(
   parameter int GRID_WIDTH  = 100,
   parameter int GRID_HEIGHT = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lag_pkg::lag_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lag_pkg::lag_rsp_type rsp_data
);
   import lag_pkg::*;

   localparam int ROW_W = $clog2(GRID_HEIGHT);
   localparam int COL_W = $clog2(GRID_WIDTH);

   lag_state_type state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   lag_req_type      req_ff;
   logic             alive_ff;
   logic [GRID_WIDTH-1:0] prev_ff, cur_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   lag_rsp_type      rsp_data_ff;

   logic                  req_xfer;
   logic                  req_in_grid;
   logic                  last_row;
   logic                  rsp_load;
   logic [COL_W-1:0]      col;
   logic [GRID_WIDTH-1:0] rd_data;
   logic [GRID_WIDTH-1:0] set_row;
   logic [GRID_WIDTH-1:0] below_row;
   logic [GRID_WIDTH-1:0] new_row;
   logic                  wr_en;
   logic [ROW_W-1:0]      wr_addr;
   logic [GRID_WIDTH-1:0] wr_data;
   logic [ROW_W-1:0]      rd_addr;

   lag_cell_mem #(
      .ROWS (GRID_HEIGHT),
      .COLS (GRID_WIDTH)
   ) u_cell_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lag_next_row #(
      .GRID_WIDTH (GRID_WIDTH)
   ) u_next_row (
      .prev_row (prev_ff),
      .cur_row  (cur_ff),
      .next_row (below_row),
      .new_row  (new_row)
   );

   assign req_xfer    = req_valid && !req_stall;
   assign req_in_grid = (32'(req_data.cell_x) < GRID_WIDTH) &&
                        (32'(req_data.cell_y) < GRID_HEIGHT);
   assign last_row    = (row_ff == ROW_W'(GRID_HEIGHT - 1));
   assign rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign col         = COL_W'(req_ff.cell_x);
   // bottom row sees dead cells below
   assign below_row   = last_row ? '0 : rd_data;

   always_comb begin
      set_row      = rd_data;
      set_row[col] = 1'b1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            row_in = row_ff + ROW_W'(1);
            if (last_row) begin
               state_in = ST_IDLE;
               row_in   = '0;
            end
         end
         ST_IDLE: begin
            row_in = '0;
            if (req_xfer) begin
               unique case (req_data.req_type) inside
                  KIND_SET, KIND_READ: state_in = req_in_grid ? ST_ACCESS : ST_DONE;
                  KIND_STEP:           state_in = ST_PRIME;
                  default:             state_in = ST_DONE;
               endcase
            end
         end
         ST_ACCESS: state_in = ST_DONE;
         ST_PRIME:  state_in = ST_SWEEP;
         ST_SWEEP: begin
            row_in = row_ff + ROW_W'(1);
            if (last_row) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and memory control
   always_comb begin
      req_stall = 1'b1;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = row_ff;
      wr_data   = new_row;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_data.req_type != KIND_STEP) begin
               rd_addr = ROW_W'(req_data.cell_y);
            end
         end
         ST_ACCESS: begin
            wr_en   = (req_ff.req_type == KIND_SET);
            wr_addr = ROW_W'(req_ff.cell_y);
            wr_data = set_row;
         end
         ST_PRIME: rd_addr = ROW_W'(1);
         ST_SWEEP: begin
            // two rows ahead of the row being written back
            rd_addr = row_ff + ROW_W'(2);
            wr_en   = 1'b1;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff   <= req_data;
         alive_ff <= 1'b0;
      end
      if (state_ff == ST_ACCESS && req_ff.req_type == KIND_READ) begin
         alive_ff <= rd_data[col];
      end
      if (state_ff == ST_PRIME) begin
         prev_ff <= '0;
         cur_ff  <= rd_data;
      end
      if (state_ff == ST_SWEEP) begin
         prev_ff <= cur_ff;
         cur_ff  <= rd_data;
      end
      if (rsp_load) begin
         rsp_data_ff.cell_alive <= alive_ff;
         rsp_data_ff.done_kind  <= req_ff.req_type;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/lag_checker.sv -----
// port-level checks for the life automaton grid, bound to the top level
// depends on lag_pkg and life_automaton_grid_defines.svh
`include "life_automaton_grid_defines.svh"

module lag_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input lag_pkg::lag_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input lag_pkg::lag_rsp_type rsp_data
);
   import lag_pkg::*;

   // a stalled response holds
   `LAG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "response changed while stalled")

   // one request at a time: a transfer closes the input side
   `LAG_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "request taken while busy")

   // clearing pass keeps the input side closed straight after reset
   `LAG_ASSERT_NOW(a_clear_stall, $fell(reset), req_stall, "request side open during clearing")

   // only a read can report a live cell
   `LAG_ASSERT_NOW(a_alive_read_only, rsp_valid && rsp_data.done_kind != KIND_READ, !rsp_data.cell_alive, "live cell on non-read response")

endmodule

bind life_automaton_grid lag_checker u_lag_checker (.*);
